[rtl/mlbt_pkg.sv]
// ----------------------------------------------------------------------------
// mlbt_pkg
// Types, codes and constants shared by the motor load baseline tracker.
// ----------------------------------------------------------------------------
package mlbt_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned RpmW    = 16;
  localparam int unsigned LoadW   = 8;
  localparam int unsigned SpanW   = 20;  // 16 bit rpm step times 4 bit ms/rpm
  localparam int unsigned TolProdW = 23; // 16 bit target times 7 bit percent
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  // floor(x / 100) == (x * TolRecip) >> TolShift for every 23 bit x
  localparam logic [23:0] TolRecip = 24'd10737419;
  localparam int unsigned TolShift = 30;

  localparam logic signed [8:0] DeltaMax = 9'sd100;
  localparam logic signed [8:0] DeltaMin = -9'sd100;

  localparam logic [15:0] GraceFloorRst  = 16'd500;
  localparam logic [3:0]  GracePerRst    = 4'd1;
  localparam logic [15:0] StableFloorRst = 16'd2000;
  localparam logic [3:0]  StablePerRst   = 4'd1;
  localparam logic [6:0]  TolPctRst      = 7'd5;
  localparam logic [9:0]  MinTolRst      = 10'd25;

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_CHANGE = 2'd2,
    FUNC_STOP   = 2'd3
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GRACE_FLOOR  = 3'd0,
    CFG_GRACE_PER    = 3'd1,
    CFG_STABLE_FLOOR = 3'd2,
    CFG_STABLE_PER   = 3'd3,
    CFG_TOL_PCT      = 3'd4,
    CFG_MIN_TOL      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] grace_floor_ms;
    logic [3:0]  grace_ms_per_rpm;
    logic [15:0] stable_floor_ms;
    logic [3:0]  stable_ms_per_rpm;
    logic [6:0]  tolerance_pct;
    logic [9:0]  min_tolerance_rpm;
  } cfg_t;

  typedef struct packed {
    func_e            func;
    logic [TimeW-1:0] now_ms;
    logic [LoadW-1:0] load_raw;
    logic [RpmW-1:0]  measured_rpm;
    logic [RpmW-1:0]  set_rpm;
    logic [RpmW-1:0]  prev_set_rpm;
    logic             running;
  } item_t;

  // Item after the state-free arithmetic, ready for the state update
  typedef struct packed {
    func_e            func;
    logic [TimeW-1:0] now_ms;
    logic [LoadW-1:0] load_raw;
    logic             running;
    logic             target_nz;
    logic             speed_ok;
    logic             changed;
    logic             step_up;
    logic [TimeW-1:0] grace_cand;
    logic [SpanW-1:0] stable_len;
  } prep_t;

  typedef struct packed {
    logic [LoadW-1:0]        load_avg;
    logic [LoadW-1:0]        load_last;
    logic signed [LoadW-1:0] step_delta;
    logic                    baseline_valid;
    logic [LoadW-1:0]        baseline_load;
    logic                    in_spike_grace;
  } result_t;

  // Wrap-safe "a is later than b"
  function automatic logic ahead(logic [TimeW-1:0] a, logic [TimeW-1:0] b);
    logic [TimeW-1:0] diff;
    diff = a - b;
    return (diff != '0) && !diff[TimeW-1];
  endfunction

endpackage

[rtl/mlbt_if.sv]
// ----------------------------------------------------------------------------
// mlbt_in_if / mlbt_out_if
// Valid/ready channels carrying event items in and tracker results out.
// ----------------------------------------------------------------------------
interface mlbt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] now_ms;
  logic [7:0]  load_raw;
  logic [15:0] measured_rpm;
  logic [15:0] set_rpm;
  logic [15:0] prev_set_rpm;
  logic        running;

  modport source (
    output valid, func, now_ms, load_raw, measured_rpm, set_rpm, prev_set_rpm,
           running,
    input  ready
  );
  modport sink (
    input  valid, func, now_ms, load_raw, measured_rpm, set_rpm, prev_set_rpm,
           running,
    output ready
  );
endinterface

interface mlbt_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        load_avg;
  logic [7:0]        load_last;
  logic signed [7:0] step_delta;
  logic              baseline_valid;
  logic [7:0]        baseline_load;
  logic              in_spike_grace;

  modport source (
    output valid, load_avg, load_last, step_delta, baseline_valid,
           baseline_load, in_spike_grace,
    input  ready
  );
  modport sink (
    input  valid, load_avg, load_last, step_delta, baseline_valid,
           baseline_load, in_spike_grace,
    output ready
  );
endinterface

[rtl/mlbt_cfg.sv]
// ----------------------------------------------------------------------------
// mlbt_cfg
// Configuration register file with write-only indexed access.
// ----------------------------------------------------------------------------
module mlbt_cfg
  import mlbt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  logic [CfgIdxW-1:0]  idx_i,
  input  logic [CfgDataW-1:0] wdata_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_GRACE_FLOOR:  cfg_d.grace_floor_ms    = wdata_i;
        CFG_GRACE_PER:    cfg_d.grace_ms_per_rpm  = wdata_i[3:0];
        CFG_STABLE_FLOOR: cfg_d.stable_floor_ms   = wdata_i;
        CFG_STABLE_PER:   cfg_d.stable_ms_per_rpm = wdata_i[3:0];
        CFG_TOL_PCT:      cfg_d.tolerance_pct     = wdata_i[6:0];
        CFG_MIN_TOL:      cfg_d.min_tolerance_rpm = wdata_i[9:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grace_floor_ms    <= GraceFloorRst;
      cfg_q.grace_ms_per_rpm  <= GracePerRst;
      cfg_q.stable_floor_ms   <= StableFloorRst;
      cfg_q.stable_ms_per_rpm <= StablePerRst;
      cfg_q.tolerance_pct     <= TolPctRst;
      cfg_q.min_tolerance_rpm <= MinTolRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/mlbt_prep.sv]
// ----------------------------------------------------------------------------
// mlbt_prep
// Input register and two stages of state-free arithmetic: speed step spans,
// tolerance window test and candidate grace deadline.
// ----------------------------------------------------------------------------
module mlbt_prep
  import mlbt_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output prep_t out_prep_o
);

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_en, s2_en, s3_en;

  item_t s1_q;

  item_t               s2_item_q;
  logic [SpanW-1:0]    s2_grace_len_q, s2_stable_len_q;
  logic [TolProdW-1:0] s2_tol_prod_q;
  logic                s2_changed_q, s2_step_up_q;

  prep_t s3_q, s3_d;

  // Stage 1 -> 2
  logic [RpmW-1:0]     span_rpm;
  logic                step_up, changed;
  logic [SpanW-1:0]    grace_prod, stable_prod, grace_floor, stable_floor;
  logic [SpanW-1:0]    grace_len, stable_len;
  logic [TolProdW-1:0] tol_prod;

  // Stage 2 -> 3
  logic [TolProdW+24-1:0] quot_full;
  logic [RpmW-1:0]        tol_raw, tol, win_lo, win_hi;

  // Advance a stage when it is empty or its contents move on
  assign s3_en = !s3_valid_q || out_ready_i;
  assign s2_en = !s2_valid_q || s3_en;
  assign s1_en = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  always_comb begin
    step_up = s1_q.set_rpm > s1_q.prev_set_rpm;
    changed = s1_q.set_rpm != s1_q.prev_set_rpm;
    if (s1_q.func == FUNC_START) begin
      span_rpm = s1_q.set_rpm;
    end else if (step_up) begin
      span_rpm = s1_q.set_rpm - s1_q.prev_set_rpm;
    end else begin
      span_rpm = s1_q.prev_set_rpm - s1_q.set_rpm;
    end
    grace_prod   = {4'b0, span_rpm} * {16'b0, cfg_i.grace_ms_per_rpm};
    stable_prod  = {4'b0, span_rpm} * {16'b0, cfg_i.stable_ms_per_rpm};
    grace_floor  = {4'b0, cfg_i.grace_floor_ms};
    stable_floor = {4'b0, cfg_i.stable_floor_ms};
    grace_len    = (grace_prod > grace_floor) ? grace_prod : grace_floor;
    stable_len   = (stable_prod > stable_floor) ? stable_prod : stable_floor;
    tol_prod     = {7'b0, s1_q.set_rpm} * {16'b0, cfg_i.tolerance_pct};
  end

  always_comb begin
    quot_full = {24'b0, s2_tol_prod_q} * {{TolProdW{1'b0}}, TolRecip};
    tol_raw   = quot_full[TolShift+RpmW-1:TolShift];
    tol       = (tol_raw < {6'b0, cfg_i.min_tolerance_rpm}) ?
                {6'b0, cfg_i.min_tolerance_rpm} : tol_raw;
    win_lo    = (s2_item_q.set_rpm > tol) ? s2_item_q.set_rpm - tol : '0;
    win_hi    = s2_item_q.set_rpm + tol;  // wraps modulo 2^16

    s3_d.func       = s2_item_q.func;
    s3_d.now_ms     = s2_item_q.now_ms;
    s3_d.load_raw   = s2_item_q.load_raw;
    s3_d.running    = s2_item_q.running;
    s3_d.target_nz  = s2_item_q.set_rpm != '0;
    s3_d.speed_ok   = (s2_item_q.measured_rpm >= win_lo) &&
                      (s2_item_q.measured_rpm <= win_hi);
    s3_d.changed    = s2_changed_q;
    s3_d.step_up    = s2_step_up_q;
    s3_d.grace_cand = s2_item_q.now_ms + {12'b0, s2_grace_len_q};
    s3_d.stable_len = s2_stable_len_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
      if (s3_en) s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_q <= in_item_i;
    end
    if (s2_en && s1_valid_q) begin
      s2_item_q       <= s1_q;
      s2_grace_len_q  <= grace_len;
      s2_stable_len_q <= stable_len;
      s2_tol_prod_q   <= tol_prod;
      s2_changed_q    <= changed;
      s2_step_up_q    <= step_up;
    end
    if (s3_en && s2_valid_q) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_prep_o  = s3_q;

endmodule

[rtl/mlbt_core.sv]
// ----------------------------------------------------------------------------
// mlbt_core
// Tracker state update (load filter, raw history, baseline learning, grace
// deadline) and the result register.
// ----------------------------------------------------------------------------
module mlbt_core
  import mlbt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  prep_t   in_prep_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  logic [LoadW-1:0] avg_q, avg_d;
  logic             avg_started_q, avg_started_d;
  logic [LoadW-1:0] newest_q, newest_d;
  logic [LoadW-1:0] older_q, older_d;
  logic             older_valid_q, older_valid_d;
  logic [LoadW-1:0] learned_q, learned_d;
  logic             latched_q, latched_d;
  logic [TimeW-1:0] grace_q, grace_d;
  logic [TimeW-1:0] entry_q, entry_d;
  logic [SpanW-1:0] needed_q, needed_d;

  logic             out_valid_q;
  result_t          res_q, res_d;
  logic             take;

  logic [10:0]       avg_sum;
  logic [TimeW-1:0]  elapsed;
  logic signed [8:0] raw_diff;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    avg_d         = avg_q;
    avg_started_d = avg_started_q;
    newest_d      = newest_q;
    older_d       = older_q;
    older_valid_d = older_valid_q;
    learned_d     = learned_q;
    latched_d     = latched_q;
    grace_d       = grace_q;
    entry_d       = entry_q;
    needed_d      = needed_q;

    avg_sum = {3'b0, avg_q} * 11'd7 + {3'b0, in_prep_i.load_raw} + 11'd4;
    elapsed = in_prep_i.now_ms - entry_q;

    unique case (in_prep_i.func)
      FUNC_SAMPLE: begin
        if (!in_prep_i.running) begin
          avg_d = '0; avg_started_d = 1'b0;
          newest_d = '0; older_d = '0; older_valid_d = 1'b0;
          learned_d = '0; latched_d = 1'b0; entry_d = '0;
        end else begin
          if (avg_started_q) begin
            older_d       = newest_q;
            older_valid_d = 1'b1;
            avg_d         = avg_sum[10:3];
          end else begin
            avg_d = in_prep_i.load_raw;
          end
          avg_started_d = 1'b1;
          newest_d      = in_prep_i.load_raw;
          if (!latched_q && in_prep_i.target_nz) begin
            if (in_prep_i.speed_ok) begin
              // an entry stamped at time zero still reads as outside
              if (entry_q == '0) begin
                entry_d = in_prep_i.now_ms;
              end else if (elapsed >= {12'b0, needed_q}) begin
                learned_d = avg_d;
                latched_d = 1'b1;
              end
            end else begin
              entry_d = '0;
            end
          end
        end
      end
      FUNC_START: begin
        grace_d  = in_prep_i.grace_cand;
        needed_d = in_prep_i.stable_len;
        avg_d = '0; avg_started_d = 1'b0;
        newest_d = '0; older_d = '0; older_valid_d = 1'b0;
        learned_d = '0; latched_d = 1'b0; entry_d = '0;
      end
      FUNC_CHANGE: begin
        if (in_prep_i.changed) begin
          if (in_prep_i.step_up && ahead(in_prep_i.grace_cand, grace_q)) begin
            grace_d = in_prep_i.grace_cand;
          end
          latched_d = 1'b0;
          learned_d = '0;
          entry_d   = '0;
          needed_d  = in_prep_i.stable_len;
        end
      end
      FUNC_STOP: begin
        avg_d = '0; avg_started_d = 1'b0;
        newest_d = '0; older_d = '0; older_valid_d = 1'b0;
        learned_d = '0; latched_d = 1'b0; entry_d = '0;
        grace_d = '0; needed_d = '0;
      end
      default: ;
    endcase

    raw_diff = $signed({1'b0, newest_d}) - $signed({1'b0, older_d});

    res_d.load_avg  = avg_d;
    res_d.load_last = newest_d;
    if (!older_valid_d) begin
      res_d.step_delta = '0;
    end else if (raw_diff > DeltaMax) begin
      res_d.step_delta = DeltaMax[LoadW-1:0];
    end else if (raw_diff < DeltaMin) begin
      res_d.step_delta = DeltaMin[LoadW-1:0];
    end else begin
      res_d.step_delta = raw_diff[LoadW-1:0];
    end
    res_d.baseline_valid = latched_d;
    res_d.baseline_load  = latched_d ? learned_d : '0;
    res_d.in_spike_grace = (grace_d != '0) && ahead(grace_d, in_prep_i.now_ms);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q         <= '0;
      avg_started_q <= 1'b0;
      newest_q      <= '0;
      older_q       <= '0;
      older_valid_q <= 1'b0;
      learned_q     <= '0;
      latched_q     <= 1'b0;
      grace_q       <= '0;
      entry_q       <= '0;
      needed_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (take) begin
        avg_q         <= avg_d;
        avg_started_q <= avg_started_d;
        newest_q      <= newest_d;
        older_q       <= older_d;
        older_valid_q <= older_valid_d;
        learned_q     <= learned_d;
        latched_q     <= latched_d;
        grace_q       <= grace_d;
        entry_q       <= entry_d;
        needed_q      <= needed_d;
      end
      if (in_ready_o) out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

[rtl/motor_load_baseline_tracker.sv]
// ----------------------------------------------------------------------------
// motor_load_baseline_tracker
// Motor load filter with idle-baseline learning and inrush grace tracking.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one event item (sample, start, speed change, stop) with a
//          millisecond time stamp; out_ch returns exactly one result per item,
//          in order: filtered load, last raw load, clamped step delta,
//          baseline valid/value and the inrush grace flag.
//   The config port writes one register per cycle when cfg_we_i is high;
//   change registers only while no item is in flight.
//   The accepting edge loads the input register, followed by two arithmetic
//   stages (span products, then the divide-by-100 reciprocal multiply and
//   window test) and the state update that loads the result register.
//   Throughput is one item per cycle while out_ch is not stalled; the state
//   update closes its loop in the same cycle, so items never wait on each other.
//   Reset clears all tracking state, empties the pipeline and loads the
//   register defaults. When the receiver stalls, the result register holds
//   and the stages behind it keep filling; with four items held, in_ch.ready
//   drops until out_ch moves again.
// ----------------------------------------------------------------------------
module motor_load_baseline_tracker
  import mlbt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  mlbt_in_if.sink             in_ch,
  mlbt_out_if.source          out_ch,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t    cfg;
  item_t   in_item;
  prep_t   prep;
  logic    prep_valid, prep_ready;
  result_t res;

  mlbt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  always_comb begin
    in_item.func         = func_e'(in_ch.func);
    in_item.now_ms       = in_ch.now_ms;
    in_item.load_raw     = in_ch.load_raw;
    in_item.measured_rpm = in_ch.measured_rpm;
    in_item.set_rpm      = in_ch.set_rpm;
    in_item.prev_set_rpm = in_ch.prev_set_rpm;
    in_item.running      = in_ch.running;
  end

  mlbt_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .in_item_i   (in_item),
    .out_valid_o (prep_valid),
    .out_ready_i (prep_ready),
    .out_prep_o  (prep)
  );

  mlbt_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (prep_valid),
    .in_ready_o  (prep_ready),
    .in_prep_i   (prep),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_res_o   (res)
  );

  assign out_ch.load_avg       = res.load_avg;
  assign out_ch.load_last      = res.load_last;
  assign out_ch.step_delta     = res.step_delta;
  assign out_ch.baseline_valid = res.baseline_valid;
  assign out_ch.baseline_load  = res.baseline_load;
  assign out_ch.in_spike_grace = res.in_spike_grace;

endmodule

[rtl/mlbt_checker.sv]
// ----------------------------------------------------------------------------
// mlbt_checker
// Port-level checks for the motor load baseline tracker.
// ----------------------------------------------------------------------------
module mlbt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [7:0]        load_avg_i,
  input logic signed [7:0] step_delta_i,
  input logic              baseline_valid_i,
  input logic [7:0]        baseline_load_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable(load_avg_i) && $stable(step_delta_i) && $stable(baseline_load_i))
    else $error("stalled result changed");

  a_delta_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (step_delta_i <= 8'sd100) && (step_delta_i >= -8'sd100))
    else $error("step delta outside clamp range");

  a_baseline_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !baseline_valid_i |-> baseline_load_i == 8'd0)
    else $error("baseline load shown without a latched baseline");

endmodule

bind motor_load_baseline_tracker mlbt_checker u_mlbt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_ch.valid),
  .out_ready_i      (out_ch.ready),
  .load_avg_i       (out_ch.load_avg),
  .step_delta_i     (out_ch.step_delta),
  .baseline_valid_i (out_ch.baseline_valid),
  .baseline_load_i  (out_ch.baseline_load)
);
